// ===== rtl/core/fcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared types, constants and lookup tables of the filmic color grade
// pipeline: fixed-point format, filmic and luma coefficients, register map,
// stage counts and the log2 / exp2 interpolation tables.
// ----------------------------------------------------------------------------
package fcg_pkg;

    // Fixed-point format
    localparam int F    = 12;
    localparam int ONE  = 1 << F;
    localparam int HALF = ONE / 2;

    // Interpolation tables
    localparam int L     = 8;
    localparam int TBL_N = (1 << L) + 1;
    localparam int TSH   = 30 - L;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    // Field widths
    localparam int PIX_W  = 16;
    localparam int CFG_W  = 14;
    localparam int LIFT_W = 12;
    localparam int OUT_W  = 13;
    localparam int IDX_W  = 3;
    localparam int X_W    = 18;   // exposed value
    localparam int T_W    = 20;   // filmic inner terms
    localparam int ND_W   = 38;   // numerator / denominator
    localparam int Q_W    = 14;   // quotient bits
    localparam int C_W    = 16;   // signed contrast result
    localparam int V_W    = 21;   // power curve result

    // Filmic curve coefficients, rounded to nearest
    localparam int FA = (251 * ONE + 50) / 100;
    localparam int FB = (3 * ONE + 50) / 100;
    localparam int FC = (243 * ONE + 50) / 100;
    localparam int FD = (59 * ONE + 50) / 100;
    localparam int FE = (14 * ONE + 50) / 100;

    // Rec.601 luma weights
    localparam int LW_R = (299 * ONE + 500) / 1000;
    localparam int LW_G = (587 * ONE + 500) / 1000;
    localparam int LW_B = (114 * ONE + 500) / 1000;

    // Pipeline stage counts
    localparam int TONE_STAGES  = Q_W + 6;
    localparam int POW_STAGES   = 8;
    localparam int GRADE_STAGES = 8;
    localparam int PIPE_DEPTH   = TONE_STAGES + POW_STAGES + GRADE_STAGES;

    // Register map
    localparam logic [IDX_W-1:0] CFG_EXPOSURE   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CONTRAST   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_POWER      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SATURATION = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LIFT       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HIGHLIGHT  = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0]         exposure_gain;
        logic [CFG_W-1:0]         contrast_gain;
        logic [CFG_W-1:0]         power_exponent;
        logic [CFG_W-1:0]         saturation_gain;
        logic signed [LIFT_W-1:0] lift_amount;
        logic [CFG_W-1:0]         highlight_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        exposure_gain:   14'd4096,
        contrast_gain:   14'd4096,
        power_exponent:  14'd4096,
        saturation_gain: 14'd4096,
        lift_amount:     12'sd0,
        highlight_gain:  14'd4096
    };

    typedef logic [TBL_N-1:0][31:0] t_tab;

    // Product rescale by 2^F, rounded half away from zero
    function automatic logic signed [47:0] mulq_rnd(input logic signed [47:0] p);
        logic signed [47:0] mag;
        logic signed [47:0] r;
        mag = (p < 0) ? -p : p;
        r   = (mag + 48'(HALF)) >>> F;
        return (p < 0) ? -r : r;
    endfunction

    // Fractional log2 of a Q30 value in [1,2), truncated, by repeated squaring
    function automatic logic [31:0] log2_frac30(input logic [63:0] v_in);
        logic [63:0] v;
        logic [31:0] r;
        v = v_in;
        r = '0;
        for (int b = 1; b <= 30; b++) begin
            v = (v * v) >> 30;
            if (v >= 64'h8000_0000) begin
                v = v >> 1;
                r[30-b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bval;
        v    = v_in;
        r    = '0;
        bval = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bval > v) bval = bval >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (bval != 0) begin
                if (v >= r + bval) begin
                    v = v - (r + bval);
                    r = (r >> 1) + bval;
                end else begin
                    r = r >> 1;
                end
                bval = bval >> 2;
            end
        end
        return r;
    endfunction

    function automatic t_tab build_log_tab();
        t_tab t;
        for (int i = 0; i < TBL_N; i++) begin
            t[i] = log2_frac30(Q30 + (64'(i) << TSH));
        end
        t[TBL_N-1] = 32'(Q30);
        return t;
    endfunction

    function automatic t_tab build_exp_tab();
        t_tab        t;
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int i = 0; i < L; i++) begin
            root = isqrt64(root << 30);
        end
        t[0] = 32'(Q30);
        for (int i = 1; i < TBL_N; i++) begin
            t[i] = 32'((64'(t[i-1]) * root + (64'd1 << 29)) >> 30);
        end
        t[TBL_N-1] = 32'(2 * Q30);
        return t;
    endfunction

    localparam t_tab LOG_TAB = build_log_tab();
    localparam t_tab EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/core/fcg_tone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_tone
// One channel: exposure scale, rational filmic curve with a restoring
// divider of one quotient bit per stage, then contrast about one half.
// ----------------------------------------------------------------------------
module fcg_tone import fcg_pkg::*; (
    input  logic                    i_clk,
    input  logic [TONE_STAGES-1:0]  i_en,
    input  logic [PIX_W-1:0]        i_pix,
    input  t_cfg                    i_cfg,
    output logic signed [C_W-1:0]   o_c
);

    localparam int S_DIV = 4;
    localparam int S_CP  = S_DIV + Q_W;
    localparam int S_C   = S_CP + 1;

    logic [29:0]       x_sum;
    logic [31:0]       t1_sum;
    logic [31:0]       t2_sum;
    logic [50:0]       n_full;
    logic signed [15:0] y_s;
    logic signed [14:0] cg_s;

    logic [X_W-1:0]    r_x0;
    logic [X_W-1:0]    r_x1;
    logic [T_W-1:0]    r_t1;
    logic [T_W-1:0]    r_t2;
    logic [ND_W-1:0]   r_num;
    logic [ND_W-1:0]   r_den;
    logic [ND_W-1:0]   r_rem [0:Q_W-1];
    logic [ND_W-1:0]   r_dv  [0:Q_W-1];
    logic [Q_W-1:0]    r_low [0:Q_W];
    logic signed [30:0] r_cp;
    logic signed [C_W-1:0] r_c;

    // Exposure scale
    assign x_sum = 30'(i_pix) * 30'(i_cfg.exposure_gain) + 30'(HALF);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x0 <= x_sum[F+X_W-1:F];
        end
    end

    // Filmic inner terms A*x+B and C*x+D
    assign t1_sum = 32'(r_x0) * 32'(FA) + 32'(FB * ONE + HALF);
    assign t2_sum = 32'(r_x0) * 32'(FC) + 32'(FD * ONE + HALF);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t1 <= t1_sum[F+T_W-1:F];
            r_t2 <= t2_sum[F+T_W-1:F];
            r_x1 <= r_x0;
        end
    end

    // Numerator and denominator
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num <= ND_W'(r_x1) * ND_W'(r_t1);
            r_den <= ND_W'(r_x1) * ND_W'(r_t2) + ND_W'(FE * ONE);
        end
    end

    // Dividend with half-up rounding; upper bits seed the remainder
    assign n_full = (51'(r_num) << F) + 51'(r_den >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_rem[0] <= ND_W'(n_full[50:Q_W]);
            r_low[0] <= n_full[Q_W-1:0];
            r_dv[0]  <= r_den;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        logic [ND_W:0] rem2;
        logic [ND_W:0] dif;
        logic          ge;

        assign rem2 = {r_rem[g], r_low[g][Q_W-1]};
        assign dif  = rem2 - {1'b0, r_dv[g]};
        assign ge   = rem2 >= {1'b0, r_dv[g]};

        always_ff @(posedge i_clk) begin
            if (i_en[S_DIV+g]) begin
                r_low[g+1] <= {r_low[g][Q_W-2:0], ge};
            end
        end

        if (g < Q_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[S_DIV+g]) begin
                    r_rem[g+1] <= ge ? dif[ND_W-1:0] : rem2[ND_W-1:0];
                    r_dv[g+1]  <= r_dv[g];
                end
            end
        end
    end

    // Contrast about one half
    assign y_s  = signed'(16'(r_low[Q_W])) - 16'sd2048;
    assign cg_s = signed'({1'b0, i_cfg.contrast_gain});

    always_ff @(posedge i_clk) begin
        if (i_en[S_CP]) begin
            r_cp <= 31'(y_s) * 31'(cg_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[S_C]) begin
            r_c <= C_W'(mulq_rnd(48'(r_cp)) + 48'(HALF));
        end
    end

    assign o_c = r_c;

endmodule

// ===== rtl/core/fcg_power.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_power
// One channel: power curve as exp2(exponent * log2(c)), both through
// linearly interpolated tables. Non-positive input gives zero, a zero
// exponent gives one and takes priority over the zero cases.
// ----------------------------------------------------------------------------
module fcg_power import fcg_pkg::*; (
    input  logic                    i_clk,
    input  logic [POW_STAGES-1:0]   i_en,
    input  logic signed [C_W-1:0]   i_c,
    input  t_cfg                    i_cfg,
    output logic [V_W-1:0]          o_v
);

    logic [14:0]        cu;
    logic [3:0]         e;
    logic [14:0]        norm;
    logic [31:0]        llo;
    logic [31:0]        lhi;
    logic [30:0]        lgi;
    logic [31:0]        lgs;
    logic signed [17:0] lg;
    logic signed [14:0] pe_s;
    logic signed [20:0] z;
    logic signed [8:0]  k;
    logic signed [8:0]  sv;
    logic [31:0]        elo;
    logic [31:0]        ehi;
    logic [31:0]        mant;
    logic [32:0]        rsum;
    logic [32:0]        rsh_v;

    logic [6:0]         r_pz;
    logic [6:0]         r_np;
    logic [3:0]         r_e0;
    logic [3:0]         r_e1;
    logic [3:0]         r_e2;
    logic [L-1:0]       r_idx0;
    logic [5:0]         r_rl0;
    logic [5:0]         r_rl1;
    logic [30:0]        r_llo1;
    logic [30:0]        r_llo2;
    logic [23:0]        r_ldf1;
    logic [29:0]        r_lp2;
    logic signed [17:0] r_lg3;
    logic signed [32:0] r_zp4;
    logic [31:0]        r_elo5;
    logic [31:0]        r_elo6;
    logic [23:0]        r_edf5;
    logic [3:0]         r_el5;
    logic [4:0]         r_s5;
    logic [4:0]         r_s6;
    logic               r_uf5;
    logic               r_uf6;
    logic [27:0]        r_ep6;
    logic [V_W-1:0]     r_v7;

    // Leading one and normalized mantissa
    assign cu = i_c[14:0];

    always_comb begin
        e = '0;
        for (int i = 0; i < 15; i++) begin
            if (cu[i]) e = 4'(i);
        end
    end

    assign norm = cu << (4'd14 - e);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_e0    <= e;
            r_idx0  <= norm[13:6];
            r_rl0   <= norm[5:0];
        end
    end

    // Capture the special-case flags and carry them down the stages
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pz[0] <= (i_cfg.power_exponent == '0);
            r_np[0] <= (i_c <= 0);
        end
        for (int s = 1; s < 7; s++) begin
            if (i_en[s]) begin
                r_pz[s] <= r_pz[s-1];
                r_np[s] <= r_np[s-1];
            end
        end
    end

    // Log table lookup
    assign llo = LOG_TAB[9'(r_idx0)];
    assign lhi = LOG_TAB[9'(r_idx0) + 9'd1];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_llo1 <= llo[30:0];
            r_ldf1 <= 24'(lhi - llo);
            r_rl1  <= r_rl0;
            r_e1   <= r_e0;
        end
    end

    // Log interpolation product
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_lp2  <= 30'(r_ldf1) * 30'(r_rl1);
            r_llo2 <= r_llo1;
            r_e2   <= r_e1;
        end
    end

    // Full log2 in Q.F
    assign lgi = r_llo2 + 31'(r_lp2 >> 6);
    assign lgs = 32'(lgi) + (32'd1 << (29 - F));
    assign lg  = signed'(18'(lgs[31:30-F])) +
                 ((signed'(18'(r_e2)) - 18'(F)) <<< F);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_lg3 <= lg;
        end
    end

    // Scale by the exponent
    assign pe_s = signed'({1'b0, i_cfg.power_exponent});

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_zp4 <= 33'(r_lg3) * 33'(pe_s);
        end
    end

    // Split into integer and fraction, exp table lookup
    assign z   = 21'(mulq_rnd(48'(r_zp4)));
    assign k   = z[20:F];
    assign sv  = 9'sd18 - k;
    assign elo = EXP_TAB[9'(z[F-1:4])];
    assign ehi = EXP_TAB[9'(z[F-1:4]) + 9'd1];

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_elo5 <= elo;
            r_edf5 <= 24'(ehi - elo);
            r_el5  <= z[3:0];
            r_s5   <= sv[4:0];
            r_uf5  <= (k < -9'sd13);
        end
    end

    // Exp interpolation product
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_ep6  <= 28'(r_edf5) * 28'(r_el5);
            r_elo6 <= r_elo5;
            r_s6   <= r_s5;
            r_uf6  <= r_uf5;
        end
    end

    // Rounded scale by 2^k and special cases
    assign mant  = r_elo6 + 32'(r_ep6 >> 4);
    assign rsum  = 33'(mant) + (33'd1 << (r_s6 - 5'd1));
    assign rsh_v = rsum >> r_s6;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            if (r_pz[6]) begin
                r_v7 <= V_W'(ONE);
            end else if (r_np[6] || r_uf6) begin
                r_v7 <= '0;
            end else begin
                r_v7 <= rsh_v[V_W-1:0];
            end
        end
    end

    assign o_v = r_v7;

endmodule

// ===== rtl/core/fcg_grade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_grade
// All three channels: luma, saturation about luma, lift toward one,
// highlight gain above one half and the final clamp to 0..1.
// ----------------------------------------------------------------------------
module fcg_grade import fcg_pkg::*; (
    input  logic                      i_clk,
    input  logic [GRADE_STAGES-1:0]   i_en,
    input  logic [V_W-1:0]            i_v  [3],
    input  t_cfg                      i_cfg,
    output logic [OUT_W-1:0]          o_px [3]
);

    localparam logic [11:0] LW [3] = '{12'(LW_R), 12'(LW_G), 12'(LW_B)};

    logic [33:0]        lsum;
    logic signed [14:0] sg_s;
    logic signed [14:0] hg_s;
    logic signed [22:0] d    [3];
    logic signed [26:0] w    [3];
    logic signed [27:0] t2   [3];
    logic signed [30:0] t3   [3];

    logic [33:0]        r_lp  [3];
    logic [V_W-1:0]     r_v0  [3];
    logic [V_W-1:0]     r_v1  [3];
    logic [21:0]        r_lum1;
    logic [21:0]        r_lum2;
    logic signed [37:0] r_sp  [3];
    logic signed [25:0] r_t3  [3];
    logic signed [25:0] r_t4  [3];
    logic signed [38:0] r_wp  [3];
    logic signed [27:0] r_t5  [3];
    logic signed [42:0] r_hp  [3];
    logic               r_hot [3];
    logic [OUT_W-1:0]   r_px  [3];

    assign sg_s = signed'({1'b0, i_cfg.saturation_gain});
    assign hg_s = signed'({1'b0, i_cfg.highlight_gain});

    // Weighted channel products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_lp[ch] <= 34'(i_v[ch]) * 34'(LW[ch]);
                r_v0[ch] <= i_v[ch];
            end
        end
    end

    // Luma
    assign lsum = r_lp[0] + r_lp[1] + r_lp[2] + 34'(HALF);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_lum1 <= lsum[33:F];
            r_v1   <= r_v0;
        end
    end

    // Saturation product
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            d[ch] = signed'(23'(r_v1[ch])) - signed'(23'(r_lum1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sp[ch] <= 38'(d[ch]) * 38'(sg_s);
            end
            r_lum2 <= r_lum1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_t3[ch] <= 26'(signed'(48'(r_lum2)) + mulq_rnd(48'(r_sp[ch])));
            end
        end
    end

    // Lift toward one
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w[ch] = 27'(ONE) - 27'(r_t3[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_wp[ch] <= 39'(w[ch]) * 39'(i_cfg.lift_amount);
                r_t4[ch] <= r_t3[ch];
            end
        end
    end

    // Highlight gain above one half
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            t2[ch] = 28'(48'(r_t4[ch]) + mulq_rnd(48'(r_wp[ch])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_hp[ch]  <= 43'(t2[ch] - 28'(HALF)) * 43'(hg_s);
                r_t5[ch]  <= t2[ch];
                r_hot[ch] <= t2[ch] > 28'(HALF);
            end
        end
    end

    // Clamp to 0..1
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            t3[ch] = r_hot[ch] ? 31'(48'(HALF) + mulq_rnd(48'(r_hp[ch])))
                               : 31'(r_t5[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (t3[ch] < 0) begin
                    r_px[ch] <= '0;
                end else if (t3[ch] > 31'(ONE)) begin
                    r_px[ch] <= OUT_W'(ONE);
                end else begin
                    r_px[ch] <= t3[ch][OUT_W-1:0];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            o_px <= r_px;
        end
    end

endmodule

// ===== rtl/core/filmic_color_grade_pixel.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted request passes the tone stages, with their 14
//   single-bit divider stages, then the power and grade stages.
// Throughput: one pixel per cycle while the output is not stalled; every stage
//   moves on its own, so empty stages fill even while the output is stalled.
// Reset: synchronous, active low; clears all valid bits and restores the
//   default registers. No table initialization is needed.
// ----------------------------------------------------------------------------
// filmic_color_grade_pixel
// Top level: register file, stage valid chain with per-stage advance, three
// tone and power lanes and the shared grading stages.
// ----------------------------------------------------------------------------
module filmic_color_grade_pixel import fcg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [PIX_W-1:0]    i_red_in,
    input  logic [PIX_W-1:0]    i_green_in,
    input  logic [PIX_W-1:0]    i_blue_in,
    input  logic                i_frame_end_in,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [OUT_W-1:0]    o_red_out,
    output logic [OUT_W-1:0]    o_green_out,
    output logic [OUT_W-1:0]    o_blue_out,
    output logic                o_frame_end_out,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int G_BASE = TONE_STAGES + POW_STAGES;

    t_cfg                   r_cfg;
    logic [PIPE_DEPTH-1:0]  r_vld;
    logic [PIPE_DEPTH-1:0]  r_fe;
    logic [PIPE_DEPTH:0]    en;
    logic [PIX_W-1:0]       pix [3];
    logic signed [C_W-1:0]  c_val [3];
    logic [V_W-1:0]         v_val [3];
    logic [OUT_W-1:0]       px [3];

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPOSURE:   r_cfg.exposure_gain   <= i_cfg_data;
                CFG_CONTRAST:   r_cfg.contrast_gain   <= i_cfg_data;
                CFG_POWER:      r_cfg.power_exponent  <= i_cfg_data;
                CFG_SATURATION: r_cfg.saturation_gain <= i_cfg_data;
                CFG_LIFT:       r_cfg.lift_amount     <= i_cfg_data[LIFT_W-1:0];
                CFG_HIGHLIGHT:  r_cfg.highlight_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor loads
    always_comb begin
        en[PIPE_DEPTH] = !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Frame-end flag rides alongside the data
    always_ff @(posedge i_clk) begin
        if (en[0]) r_fe[0] <= i_frame_end_in;
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (en[k]) r_fe[k] <= r_fe[k-1];
        end
    end

    assign pix[0] = i_red_in;
    assign pix[1] = i_green_in;
    assign pix[2] = i_blue_in;

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        fcg_tone u_tone (
            .i_clk (i_clk),
            .i_en  (en[TONE_STAGES-1:0]),
            .i_pix (pix[ch]),
            .i_cfg (r_cfg),
            .o_c   (c_val[ch])
        );

        fcg_power u_power (
            .i_clk (i_clk),
            .i_en  (en[TONE_STAGES +: POW_STAGES]),
            .i_c   (c_val[ch]),
            .i_cfg (r_cfg),
            .o_v   (v_val[ch])
        );
    end

    fcg_grade u_grade (
        .i_clk (i_clk),
        .i_en  (en[G_BASE +: GRADE_STAGES]),
        .i_v   (v_val),
        .i_cfg (r_cfg),
        .o_px  (px)
    );

    assign o_stall         = !en[0];
    assign o_valid         = r_vld[PIPE_DEPTH-1];
    assign o_red_out       = px[0];
    assign o_green_out     = px[1];
    assign o_blue_out      = px[2];
    assign o_frame_end_out = r_fe[PIPE_DEPTH-1];

    // Any empty stage means the input side can take a request
    a_no_stall_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_vld) < PIPE_DEPTH) |-> !o_stall)
        else $error("input stalled while the pipeline has an empty stage");

    // Unstalled output moves the last-but-one stage forward
    a_tail_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |=> (r_vld[PIPE_DEPTH-1] == $past(r_vld[PIPE_DEPTH-2])))
        else $error("final stage did not take its predecessor");

    // Graded pixels never exceed one
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_out <= OUT_W'(ONE) && o_green_out <= OUT_W'(ONE) &&
                     o_blue_out <= OUT_W'(ONE)))
        else $error("output pixel above one");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("valid bits not cleared by reset");

endmodule
